@@ design/abc_pkg.sv @@
`default_nettype none

package abc_pkg;

	localparam int AXES       = 3;
	localparam int POS_W      = 32;
	localparam int CFG_W      = 16;
	localparam int FEED_W     = 16;
	localparam int PROD_W     = 2 * CFG_W;
	localparam int LAG_W      = 27;
	localparam int AMT_W      = LAG_W + 1;
	localparam int SUM_W      = POS_W + 2;
	localparam int CFG_IDX_W  = 3;

	// floor(x / 60) = floor(floor(x / 4) / 15), and /15 is a multiply by ceil(2^35 / 15)
	localparam int DIV_SHIFT  = 35;
	localparam int DIV_IN_W   = PROD_W - 2;
	localparam int DIV_PROD_W = DIV_IN_W + 32;
	localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;

	localparam logic [CFG_IDX_W-1:0] REG_BACKLASH_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKLASH_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKLASH_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_Z    = 3'd5;

	localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd2147483648);

	typedef struct packed {
		logic adv;
		logic v_s3;
	} abc_ctl_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_MAX) begin
			r = POS_MAX[POS_W-1:0];
		end else if (v < POS_MIN) begin
			r = POS_MIN[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/abc_axis.sv @@
`default_nettype none

module abc_axis
	import abc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire abc_ctl_t                 ctl,
	input  wire logic [FEED_W-1:0]        feed_s1,
	input  wire logic                     present_s1,
	input  wire logic signed [POS_W-1:0]  target_s1,
	input  wire logic [CFG_W-1:0]         backlash,
	input  wire logic [CFG_W-1:0]         delay,
	output logic                          res_present,
	output logic signed [POS_W-1:0]       res_value
);

	logic [PROD_W-1:0]        prod_s2;
	logic                     present_s2;
	logic signed [POS_W-1:0]  target_s2;
	logic [LAG_W-1:0]         lag_s3;
	logic                     present_s3;
	logic signed [POS_W-1:0]  target_s3;
	logic signed [POS_W-1:0]  last_q;

	logic [PROD_W-1:0]        prod;
	logic [DIV_PROD_W-1:0]    div_prod;
	logic [AMT_W-1:0]         amount;
	logic signed [SUM_W-1:0]  tgt_ext;
	logic signed [SUM_W-1:0]  amt_ext;
	logic signed [SUM_W-1:0]  sum;

	assign prod     = PROD_W'(feed_s1) * PROD_W'(delay);
	assign div_prod = DIV_PROD_W'(prod_s2[PROD_W-1:2]) * DIV_PROD_W'(DIV15_MAGIC);

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s2    <= prod;
			present_s2 <= present_s1;
			target_s2  <= target_s1;
			lag_s3     <= div_prod[DIV_SHIFT +: LAG_W];
			present_s3 <= present_s2;
			target_s3  <= target_s2;
		end
	end

	assign amount  = AMT_W'(backlash) + AMT_W'(lag_s3);
	assign tgt_ext = SUM_W'(target_s3);
	assign amt_ext = signed'(SUM_W'(amount));

	always_comb begin
		priority if (target_s3 > last_q) begin
			sum = tgt_ext + amt_ext;
		end else if (target_s3 < last_q) begin
			sum = tgt_ext - amt_ext;
		end else begin
			sum = tgt_ext;
		end
	end

	// last target follows the request as it leaves for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctl.adv && ctl.v_s3 && present_s3) begin
			last_q <= target_s3;
		end
	end

	assign res_present = present_s3;
	assign res_value   = present_s3 ? sat_pos(sum) : '0;

endmodule

`default_nettype wire

@@ design/axis_backlash_compensator.sv @@
// path: an accepted request passes the input, product and divide registers, then the output register
// throughput: one request per cycle; the pipeline stalls as a whole only while
// the output register holds a result that is not taken
// stages: input register, feed times delay product, divide by 60, compare and saturate
// reset: arst_n clears stage valid bits, last targets, feedrate and registers to zero
`default_nettype none

module axis_backlash_compensator
	import abc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,

	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     x_present,
	input  wire logic signed [POS_W-1:0]  x_target,
	input  wire logic                     y_present,
	input  wire logic signed [POS_W-1:0]  y_target,
	input  wire logic                     z_present,
	input  wire logic signed [POS_W-1:0]  z_target,
	input  wire logic                     feed_present,
	input  wire logic [FEED_W-1:0]        feed_rate,

	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          x_out_valid,
	output logic signed [POS_W-1:0]       x_out,
	output logic                          y_out_valid,
	output logic signed [POS_W-1:0]       y_out,
	output logic                          z_out_valid,
	output logic signed [POS_W-1:0]       z_out
);

	logic [CFG_W-1:0]         backlash_q [AXES];
	logic [CFG_W-1:0]         delay_q    [AXES];
	logic [FEED_W-1:0]        feed_q;

	logic                     v_s1, v_s2, v_s3;
	logic [FEED_W-1:0]        feed_s1;
	logic                     present_s1 [AXES];
	logic signed [POS_W-1:0]  target_s1  [AXES];

	logic                     res_present [AXES];
	logic signed [POS_W-1:0]  res_value   [AXES];

	logic                     out_valid_q;
	logic                     present_q [AXES];
	logic signed [POS_W-1:0]  value_q   [AXES];

	logic                     adv;
	logic                     in_acc;
	logic [FEED_W-1:0]        feed_new;
	abc_ctl_t                 ctl;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign in_acc    = in_valid && adv;
	assign cfg_ready = 1'b1;
	assign feed_new  = feed_present ? feed_rate : feed_q;

	assign ctl.adv  = adv;
	assign ctl.v_s3 = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				backlash_q[i] <= '0;
				delay_q[i]    <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BACKLASH_X: backlash_q[0] <= cfg_data;
				REG_BACKLASH_Y: backlash_q[1] <= cfg_data;
				REG_BACKLASH_Z: backlash_q[2] <= cfg_data;
				REG_DELAY_X:    delay_q[0]    <= cfg_data;
				REG_DELAY_Y:    delay_q[1]    <= cfg_data;
				REG_DELAY_Z:    delay_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// feedrate is settled per request at acceptance, so later stages see it in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q <= '0;
		end else if (in_acc) begin
			feed_q <= feed_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			feed_s1       <= feed_new;
			present_s1[0] <= x_present;
			present_s1[1] <= y_present;
			present_s1[2] <= z_present;
			target_s1[0]  <= x_target;
			target_s1[1]  <= y_target;
			target_s1[2]  <= z_target;
			for (int i = 0; i < AXES; i++) begin
				present_q[i] <= res_present[i];
				value_q[i]   <= res_value[i];
			end
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		abc_axis u_axis (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.feed_s1     (feed_s1),
			.present_s1  (present_s1[a]),
			.target_s1   (target_s1[a]),
			.backlash    (backlash_q[a]),
			.delay       (delay_q[a]),
			.res_present (res_present[a]),
			.res_value   (res_value[a])
		);
	end

	assign out_valid   = out_valid_q;
	assign x_out_valid = present_q[0];
	assign x_out       = value_q[0];
	assign y_out_valid = present_q[1];
	assign y_out       = value_q[1];
	assign z_out_valid = present_q[2];
	assign z_out       = value_q[2];

endmodule

`default_nettype wire

@@ design/abc_checker.sv @@
`default_nettype none

module abc_checker
	import abc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	input  wire logic                     cfg_ready,
	input  wire logic                     in_ready,
	input  wire logic                     out_valid,
	input  wire logic                     out_ready,
	input  wire logic                     x_out_valid,
	input  wire logic signed [POS_W-1:0]  x_out,
	input  wire logic                     y_out_valid,
	input  wire logic signed [POS_W-1:0]  y_out,
	input  wire logic                     z_out_valid,
	input  wire logic signed [POS_W-1:0]  z_out
);

	// a result that is not taken holds with its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out)
			&& $stable(z_out) && $stable(x_out_valid) && $stable(y_out_valid)
			&& $stable(z_out_valid))
		else $error("stalled result changed");

	// the input side only stalls behind a waiting result
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// an absent axis reads as zero
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_out_valid || x_out == '0) && (y_out_valid || y_out == '0)
			&& (z_out_valid || z_out == '0))
		else $error("absent axis carries a value");

	// no result shortly after reset release without a request
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind axis_backlash_compensator abc_checker u_abc_checker (.*);

`default_nettype wire

@@ verif/tb_axis_backlash_compensator.sv @@
`timescale 1ns / 1ps

module tb_axis_backlash_compensator;
	import abc_pkg::*;

	localparam int LAG_DIVISOR   = 60;
	localparam int PHASES        = 6;
	localparam int RANDOM_PER    = 125;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_PRINTS    = 40;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [POS_W-1:0] TGT_MAX = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0] TGT_MIN = 32'h8000_0000;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef struct packed {
		logic [AXES-1:0]            present;
		logic [AXES-1:0][POS_W-1:0] target;
		logic                       feed_present;
		logic [FEED_W-1:0]          feed;
	} motion_cmd_t;

	typedef struct packed {
		logic [AXES-1:0]            vld;
		logic [AXES-1:0][POS_W-1:0] pos;
	} axis_result_t;

	class motion_scoreboard;
		logic [CFG_W-1:0]  backlash [AXES];
		logic [CFG_W-1:0]  delay    [AXES];
		logic [POS_W-1:0]  last_pos [AXES];
		logic [FEED_W-1:0] feed;
		axis_result_t      pending_q[$];
		int                errors;
		int                results_seen;

		function new();
			for (int a = 0; a < AXES; a++) begin
				backlash[a] = '0;
				delay[a]    = '0;
				last_pos[a] = '0;
			end
			feed         = '0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_BACKLASH_X: backlash[0] = data;
				REG_BACKLASH_Y: backlash[1] = data;
				REG_BACKLASH_Z: backlash[2] = data;
				REG_DELAY_X:    delay[0]    = data;
				REG_DELAY_Y:    delay[1]    = data;
				REG_DELAY_Z:    delay[2]    = data;
				default:        ;
			endcase
		endfunction

		// feed update lands before the lag of this same request is formed
		function void note_command(motion_cmd_t c);
			axis_result_t   r;
			longint         tgt;
			longint         prev;
			longint         amount;
			longint         sum;
			longint unsigned prod;
			if (c.feed_present) feed = c.feed;
			r = '0;
			for (int a = 0; a < AXES; a++) begin
				r.vld[a] = c.present[a];
				if (c.present[a]) begin
					tgt    = $signed(c.target[a]);
					prev   = $signed(last_pos[a]);
					prod   = longint'(feed) * longint'(delay[a]);
					amount = longint'(backlash[a]) + longint'(prod / LAG_DIVISOR);
					sum    = tgt;
					if (tgt > prev) sum = tgt + amount;
					else if (tgt < prev) sum = tgt - amount;
					if (sum > SAT_HI) sum = SAT_HI;
					if (sum < SAT_LO) sum = SAT_LO;
					r.pos[a]    = sum[POS_W-1:0];
					last_pos[a] = c.target[a];
				end
			end
			pending_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(axis_result_t got);
			axis_result_t want;
			results_seen++;
			if (pending_q.size() == 0) begin
				report("result arrived with no request pending");
			end else begin
				want = pending_q.pop_front();
				for (int a = 0; a < AXES; a++) begin
					if (got.vld[a] !== want.vld[a])
						report($sformatf("axis %0d valid %b, expected %b",
							a, got.vld[a], want.vld[a]));
					if (got.pos[a] !== want.pos[a])
						report($sformatf("axis %0d position %0d, expected %0d",
							a, $signed(got.pos[a]), $signed(want.pos[a])));
				end
			end
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    x_present = 1'b0;
	logic signed [POS_W-1:0] x_target = '0;
	logic                    y_present = 1'b0;
	logic signed [POS_W-1:0] y_target = '0;
	logic                    z_present = 1'b0;
	logic signed [POS_W-1:0] z_target = '0;
	logic                    feed_present = 1'b0;
	logic [FEED_W-1:0]       feed_rate = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    x_out_valid;
	logic signed [POS_W-1:0] x_out;
	logic                    y_out_valid;
	logic signed [POS_W-1:0] y_out;
	logic                    z_out_valid;
	logic signed [POS_W-1:0] z_out;

	logic             hold_on = 1'b0;
	logic [POS_W-1:0] gen_last [AXES] = '{default: '0};
	int               n_sent = 0;
	int               recv_count = 0;
	motion_scoreboard sb = new();

	axis_backlash_compensator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_present    (x_present),
		.x_target     (x_target),
		.y_present    (y_present),
		.y_target     (y_target),
		.z_present    (z_present),
		.z_target     (z_target),
		.feed_present (feed_present),
		.feed_rate    (feed_rate),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_out_valid  (x_out_valid),
		.x_out        (x_out),
		.y_out_valid  (y_out_valid),
		.y_out        (y_out),
		.z_out_valid  (z_out_valid),
		.z_out        (z_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// handshake monitors, sampled with pre-edge values
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
		if (in_valid && in_ready)
			sb.note_command({{z_present, y_present, x_present},
				{z_target, y_target, x_target}, feed_present, feed_rate});
		if (out_valid && out_ready)
			sb.check_result({{z_out_valid, y_out_valid, x_out_valid},
				{z_out, y_out, x_out}});
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int draw_wait(bit eager);
		if (eager) return 0;
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return $urandom_range(0, 2);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	// receiver: per-result stall, plus the long hold while hold_on is set
	initial begin : receiver
		int stall;
		forever begin
			stall = draw_wait(((recv_count / 25) % 4) == 0);
			if (stall != 0 || hold_on) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_on) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			recv_count++;
		end
	end

	task hold_output();
		repeat (40) @(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	endtask

	task program_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] random_reg_value();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			2:       return CFG_W'($urandom_range(1, 300));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	task apply_setting(input int phase);
		logic [CFG_W-1:0] bl [AXES];
		logic [CFG_W-1:0] dl [AXES];
		for (int a = 0; a < AXES; a++) begin
			case (phase)
				0: begin
					bl[a] = '1;
					dl[a] = '1;
				end
				1: begin
					bl[a] = '0;
					dl[a] = '0;
				end
				4: begin
					bl[a] = '0;
					dl[a] = '1;
				end
				default: begin
					bl[a] = random_reg_value();
					dl[a] = random_reg_value();
				end
			endcase
		end
		program_register(REG_BACKLASH_X, bl[0]);
		program_register(REG_BACKLASH_Y, bl[1]);
		program_register(REG_BACKLASH_Z, bl[2]);
		program_register(REG_DELAY_X, dl[0]);
		program_register(REG_DELAY_Y, dl[1]);
		program_register(REG_DELAY_Z, dl[2]);
		// out-of-range indexes must leave every register alone
		if (phase == 0) begin
			program_register(REG_SPARE_6, '0);
			program_register(REG_SPARE_7, '1);
		end else if (phase == 4) begin
			program_register(REG_SPARE_6, CFG_W'($urandom));
			program_register(REG_SPARE_7, CFG_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	task send_command(input motion_cmd_t c, input int gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		x_present    <= c.present[0];
		x_target     <= c.target[0];
		y_present    <= c.present[1];
		y_target     <= c.target[1];
		z_present    <= c.present[2];
		z_target     <= c.target[2];
		feed_present <= c.feed_present;
		feed_rate    <= c.feed;
		for (int a = 0; a < AXES; a++)
			if (c.present[a]) gen_last[a] = c.target[a];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
	endtask

	function automatic motion_cmd_t mk_command(bit xp, logic [POS_W-1:0] xt,
		bit yp, logic [POS_W-1:0] yt, bit zp, logic [POS_W-1:0] zt,
		bit fp, logic [FEED_W-1:0] f);
		motion_cmd_t c;
		c.present      = {zp, yp, xp};
		c.target       = {zt, yt, xt};
		c.feed_present = fp;
		c.feed         = f;
		return c;
	endfunction

	// targets lean toward the previous one so equal, near and saturating moves are common
	function automatic logic [POS_W-1:0] pick_target(int a);
		case ($urandom_range(0, 9))
			4:       return gen_last[a];
			5:       return gen_last[a] + POS_W'($urandom_range(1, 2000));
			6:       return gen_last[a] - POS_W'($urandom_range(1, 2000));
			7:       return TGT_MAX - POS_W'($urandom_range(0, 100));
			8:       return TGT_MIN + POS_W'($urandom_range(0, 100));
			9:       return POS_W'($urandom_range(0, 10000)) - POS_W'(5000);
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic motion_cmd_t random_command();
		motion_cmd_t c;
		for (int a = 0; a < AXES; a++) begin
			c.present[a] = ($urandom_range(0, 3) != 0);
			c.target[a]  = c.present[a] ? pick_target(a) : POS_W'($urandom);
		end
		c.feed_present = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 3))
			0:       c.feed = '0;
			1:       c.feed = '1;
			default: c.feed = FEED_W'($urandom);
		endcase
		return c;
	endfunction

	task run_random(input int count);
		for (int i = 0; i < count; i++)
			send_command(random_command(), draw_wait((i % 50) < 12));
	endtask

	// runs with backlash and delay at full scale
	task run_directed();
		send_command(mk_command(1, 1000, 1, -1000, 1, 0, 0, 0), draw_wait(0));
		send_command(mk_command(1, 1000, 0, 7, 0, 9, 1, 60), draw_wait(0));
		send_command(mk_command(1, TGT_MAX, 1, TGT_MIN, 1, 0, 1, 16'hFFFF), draw_wait(0));
		send_command(mk_command(1, TGT_MAX, 1, TGT_MIN, 1, TGT_MAX, 0, 0), draw_wait(0));
		send_command(mk_command(1, TGT_MIN, 1, TGT_MAX, 1, TGT_MIN, 0, 0), draw_wait(0));
		send_command(mk_command(0, 0, 0, 0, 0, 0, 1, 0), draw_wait(0));
		send_command(mk_command(1, TGT_MIN + 5, 1, 0, 0, 1, 0, 0), draw_wait(0));
		send_command(mk_command(1, -7, 0, 0, 1, -1, 0, 16'hFFFF), draw_wait(0));
		send_command(mk_command(1, 0, 1, 0, 1, -1, 1, 59), draw_wait(0));
		send_command(mk_command(1, -1, 1, 1, 1, -2, 1, 61), draw_wait(0));
		send_command(mk_command(0, TGT_MAX, 0, TGT_MIN, 0, -1, 0, 0), draw_wait(0));
		send_command(mk_command(1, 100, 1, 100, 1, 100, 1, 16'hFFFF), draw_wait(0));
		send_command(mk_command(1, 32'h7FFF_0000, 1, 32'h8000_FFFF, 1, 100, 0, 0),
			draw_wait(0));
		send_command(mk_command(1, 32'h7FFF_0001, 1, 32'h8000_FFFE, 1, 99, 1, 1), 0);
		send_command(mk_command(1, 32'h5555_5555, 1, 32'hAAAA_AAAA, 1, 32'h0F0F_F0F0,
			1, 16'hA5A5), 0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			apply_setting(phase);
			if (phase == 0) run_directed();
			if (phase == 2) begin
				fork
					hold_output();
					run_random(RANDOM_PER);
				join
			end else begin
				run_random(RANDOM_PER);
			end
			in_valid <= 1'b0;
			while (sb.results_seen != n_sent) @(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
